@@ rtl/core/cms_pkg.sv @@
// ----------------------------------------------------------------------------
// cms_pkg
// Shared constants, marker tables and types for the CDATA marker stripper.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int BYTE_W      = 8;
  localparam int HOLD_DEPTH  = 8;
  localparam int HOLD_IDX_W  = $clog2(HOLD_DEPTH);
  localparam int OPEN_LEN    = 9;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LOW_Z  = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_GAP  = 8'h20;

  // Opening marker "<![CDATA[" in upper case, element 0 is the first byte.
  localparam logic [OPEN_LEN-1:0][BYTE_W-1:0] OPEN_MARK = {
    8'h5B, 8'h41, 8'h54, 8'h41, 8'h44, 8'h43, 8'h5B, 8'h21, 8'h3C
  };

  // One queue entry: the bytes released by one input beat, in order.
  typedef struct packed {
    logic [OPEN_LEN-1:0][BYTE_W-1:0] bytes;
    logic [CNT_W-1:0]                count;
    logic                            doc_last;
  } cms_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cms_q_status_t;

endpackage

@@ rtl/core/cms_in_if.sv @@
// ----------------------------------------------------------------------------
// cms_in_if
// Raw byte channel: one document byte and its end flag per beat.
// ----------------------------------------------------------------------------
interface cms_in_if;
  logic                        valid;
  logic                        ready;
  logic [cms_pkg::BYTE_W-1:0]  in_byte;
  logic                        last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

@@ rtl/core/cms_out_if.sv @@
// ----------------------------------------------------------------------------
// cms_out_if
// Filtered byte channel: one released byte or an empty end marker per beat.
// ----------------------------------------------------------------------------
interface cms_out_if;
  logic                        valid;
  logic                        ready;
  logic [cms_pkg::BYTE_W-1:0]  out_byte;
  logic                        byte_valid;
  logic                        doc_end;
  logic                        run_last;

  modport source (output valid, output out_byte, output byte_valid, output doc_end,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input doc_end,
                  input run_last, output ready);
endinterface

@@ rtl/core/cdata_marker_stripper.sv @@
// ----------------------------------------------------------------------------
// cdata_marker_stripper
// Remove CDATA open and close markers from a byte stream, keep the text.
// ----------------------------------------------------------------------------
// Path: a released byte is written into a queue entry, then loaded from the
//   head entry into the output register.
// Throughput: one input byte per cycle while the queue is not full; one output
//   beat per cycle while the sink is ready, so a mismatch that releases up to nine
//   bytes drains one beat at a time while the four-entry queue keeps taking input.
// Reset: synchronous rst clears held count, section flag, queue pointers and
//   output valid; held byte storage is not cleared and is read only after a write.
// ----------------------------------------------------------------------------
module cdata_marker_stripper (
  input  logic      clk,
  input  logic      rst,
  cms_in_if.sink    raw,
  cms_out_if.source filtered
);
  import cms_pkg::*;

  // Front to queue: one entry per beat that releases bytes or ends a document.
  logic          push;
  cms_entry_t    push_entry;

  // Queue to back: head entry, fill status, and the pop when its last byte goes.
  cms_entry_t    head;
  cms_q_status_t q_status;
  logic          pop;

  // Classify each byte: hold a possible marker prefix, drop full markers,
  // release everything else together with any held bytes that stopped matching.
  cms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .raw        (raw),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // Absorb release bursts so input can keep flowing while the output drains.
  cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Emit one byte a beat; an entry with no bytes becomes the empty end marker.
  cms_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .filtered (filtered)
  );

endmodule

@@ rtl/core/cms_front.sv @@
// ----------------------------------------------------------------------------
// cms_front
// Accept raw bytes, track partial markers and the section flag, and push one
// queue entry holding the bytes that each beat releases.
// ----------------------------------------------------------------------------
module cms_front (
  input  logic                   clk,
  input  logic                   rst,
  cms_in_if.sink                 raw,
  input  cms_pkg::cms_q_status_t q_status,
  output logic                   push,
  output cms_pkg::cms_entry_t    push_entry
);
  import cms_pkg::*;

  logic [HOLD_DEPTH-1:0][BYTE_W-1:0] pending;
  logic [CNT_W-1:0]                  hold_cnt;
  logic [CNT_W-1:0]                  hold_cnt_next;
  logic                              hold_close;
  logic                              hold_close_next;
  logic                              in_section;
  logic                              in_section_next;

  logic                              accept;
  logic [BYTE_W-1:0]                 cur;
  logic [BYTE_W-1:0]                 cur_up;
  logic                              fin;
  logic [OPEN_LEN-1:0][BYTE_W-1:0]   scan;
  logic                              alone_hold_open;
  logic                              alone_hold_close;
  logic                              alone_emit;
  logic                              rel_all;
  logic                              wr_en;
  logic [HOLD_IDX_W-1:0]             wr_idx;
  logic [CNT_W-1:0]                  out_cnt;

  function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] c);
    if (c >= CH_LOW_A && c <= CH_LOW_Z) return c - CASE_GAP;
    return c;
  endfunction

  assign raw.ready = !q_status.full;
  assign accept    = raw.valid && raw.ready;
  assign cur       = raw.in_byte;
  assign fin       = raw.last_byte;
  assign cur_up    = fold_upper(cur);

  // Held bytes first, the new byte right behind them.
  always_comb begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      scan[i] = (CNT_W'(i) < hold_cnt) ? pending[i] : cur;
    end
    scan[OPEN_LEN-1] = cur;
  end

  // Fate of the new byte when it is scanned on its own.
  assign alone_hold_open  = (cur_up == CH_LT) && !fin;
  assign alone_hold_close = in_section && (cur == CH_RBRACK) && !fin;
  assign alone_emit       = !alone_hold_open && !alone_hold_close;

  always_comb begin
    hold_cnt_next   = hold_cnt;
    hold_close_next = hold_close;
    in_section_next = in_section;
    wr_en           = 1'b0;
    wr_idx          = '0;
    out_cnt         = '0;
    rel_all         = 1'b0;

    if (hold_cnt == '0) begin
      rel_all = 1'b1;
    end else if (!hold_close) begin
      if (cur_up == OPEN_MARK[hold_cnt]) begin
        if (hold_cnt == CNT_W'(OPEN_LEN - 1)) begin
          in_section_next = 1'b1;
          hold_cnt_next   = '0;
        end else if (!fin) begin
          wr_en         = 1'b1;
          wr_idx        = hold_cnt[HOLD_IDX_W-1:0];
          hold_cnt_next = hold_cnt + CNT_W'(1);
        end else begin
          rel_all = 1'b1;
        end
      end else begin
        rel_all = 1'b1;
      end
    end else begin
      if (hold_cnt == CNT_W'(1) && cur == CH_RBRACK && !fin) begin
        wr_en         = 1'b1;
        wr_idx        = hold_cnt[HOLD_IDX_W-1:0];
        hold_cnt_next = hold_cnt + CNT_W'(1);
      end else if (hold_cnt == CNT_W'(2) && cur == CH_GT) begin
        in_section_next = 1'b0;
        hold_cnt_next   = '0;
        hold_close_next = 1'b0;
      end else if (hold_cnt == CNT_W'(2) && cur == CH_RBRACK && !fin) begin
        // Three closing brackets: drop out the oldest, keep the last two held.
        out_cnt = CNT_W'(1);
      end else begin
        rel_all = 1'b1;
      end
    end

    if (rel_all) begin
      out_cnt         = hold_cnt + CNT_W'(alone_emit);
      hold_cnt_next   = alone_emit ? '0 : CNT_W'(1);
      hold_close_next = alone_hold_close && !alone_hold_open;
      wr_en           = !alone_emit;
      wr_idx          = '0;
    end

    if (fin) begin
      hold_cnt_next   = '0;
      hold_close_next = 1'b0;
      in_section_next = 1'b0;
    end
  end

  assign push                = accept && (out_cnt != '0 || fin);
  assign push_entry.bytes    = scan;
  assign push_entry.count    = out_cnt;
  assign push_entry.doc_last = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cnt   <= '0;
      hold_close <= 1'b0;
      in_section <= 1'b0;
    end else if (accept) begin
      hold_cnt   <= hold_cnt_next;
      hold_close <= hold_close_next;
      in_section <= in_section_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      pending[wr_idx] <= cur;
    end
  end

`ifndef NO_ASSERTIONS
  a_close_hold_shape: assert property (@(posedge clk) disable iff (rst)
    hold_close |-> in_section && (hold_cnt == CNT_W'(1) || hold_cnt == CNT_W'(2)))
    else $error("closing-bracket hold outside a section or of bad length");

  a_doc_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> hold_cnt == '0 && !in_section)
    else $error("state not cleared after the last byte of a document");
`endif

endmodule

@@ rtl/core/cms_queue.sv @@
// ----------------------------------------------------------------------------
// cms_queue
// Short entry queue between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module cms_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  cms_pkg::cms_entry_t    push_entry,
  input  logic                   pop,
  output cms_pkg::cms_entry_t    head,
  output cms_pkg::cms_q_status_t status
);
  import cms_pkg::*;

  cms_entry_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     fill;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head         = entries[rd_ptr];
  assign status.full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W + 1)'(1);
        2'b01:   fill <= fill - (QPTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("entry pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("entry popped from an empty queue");
`endif

endmodule

@@ rtl/core/cms_back.sv @@
// ----------------------------------------------------------------------------
// cms_back
// Walk the head queue entry one byte per beat into the output register.
// ----------------------------------------------------------------------------
module cms_back (
  input  logic                   clk,
  input  logic                   rst,
  input  cms_pkg::cms_entry_t    head,
  input  cms_pkg::cms_q_status_t q_status,
  output logic                   pop,
  cms_out_if.source              filtered
);
  import cms_pkg::*;

  logic [CNT_W-1:0]  idx;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_byte_valid;
  logic              out_doc_end;
  logic              out_run_last;
  logic              load;
  logic              entry_last;

  assign load       = !q_status.empty && (!out_valid || filtered.ready);
  assign entry_last = (head.count == '0) || (idx == head.count - CNT_W'(1));
  assign pop        = load && entry_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= entry_last ? '0 : idx + CNT_W'(1);
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= (head.count == '0) ? '0 : head.bytes[idx];
      out_byte_valid <= (head.count != '0);
      out_run_last   <= entry_last;
      out_doc_end    <= entry_last && head.doc_last;
    end
  end

  assign filtered.valid      = out_valid;
  assign filtered.out_byte   = out_byte;
  assign filtered.byte_valid = out_byte_valid;
  assign filtered.doc_end    = out_doc_end;
  assign filtered.run_last   = out_run_last;

`ifndef NO_ASSERTIONS
  a_mid_entry_needs_head: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> !q_status.empty && idx < head.count)
    else $error("emitter index past the head entry");
`endif

endmodule
